>>> sv/pgpdf_pkg.sv
// Shared types and constants for the packet stream deframer.
`default_nettype none

package pgpdf_pkg;

	// Width of the packet number shown on the result channel
	localparam int NUM_W = 20;

	// Depth of the queue between front and back
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);
	localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

	// Thresholds of the new-format first length byte
	localparam logic [7:0] NL_TWO_BASE  = 8'd192;
	localparam logic [7:0] NL_PART_BASE = 8'd224;
	localparam logic [7:0] NL_FIVE      = 8'd255;

	// Old-format type that runs to end of input when its length is indeterminate
	localparam logic [5:0] TYPE_COMPRESSED = 6'd8;

	typedef enum logic [3:0] {
		PH_TAG   = 4'd0,
		PH_NLEN1 = 4'd1,
		PH_NLEN2 = 4'd2,
		PH_LENW  = 4'd3,
		PH_BODY  = 4'd4,
		PH_OCH1  = 4'd5,
		PH_OCH2  = 4'd6,
		PH_TOEND = 4'd7
	} phase_t;

	typedef enum logic [1:0] {
		LM_DEFINITE = 2'd0,
		LM_PARTIAL  = 2'd1,
		LM_OCHUNK   = 2'd2,
		LM_TOEND    = 2'd3
	} len_mode_t;

	typedef enum logic [1:0] {
		ROLE_TAG   = 2'd0,
		ROLE_LEN   = 2'd1,
		ROLE_BODY  = 2'd2,
		ROLE_CHUNK = 2'd3
	} role_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADTAG = 2'd1,
		ST_TRUNC  = 2'd2,
		ST_END    = 2'd3
	} status_t;

	// One stream item, with its byte decoded both as a tag and as a
	// new-format first length byte
	typedef struct packed {
		logic [7:0] data;
		logic       eoi;
		logic       tag_ok;
		logic       tag_new;
		logic [5:0] tag_type;
		logic       tag_indet;
		logic       tag_toend;
		logic [2:0] tag_len_bytes;
		logic       nl_one;
		logic       nl_two;
		logic       nl_five;
		logic [4:0] nl_exp;
	} item_t;

endpackage

`default_nettype wire

>>> sv/pgp_packet_stream_deframer.sv
// Top level of the packet stream deframer: front end, queue and parser.
`default_nettype none

// Tags every byte of a packet stream with its packet number, packet type and
// role (tag, length, body or chunk length), one result per input item. The
// block takes one item per clock while the queue has room and gives one
// result per clock while items arrive and the result side is ready. A
// taken item is written into the two-entry queue behind the front end and
// is then loaded into the result register when that register is free or
// being drained. The framing state machine handles one byte per cycle
// while the result register can take it; when the result side stalls, the
// result register and the queue hold three items before the input is held
// off. An end item closes the stream: between packets it reports a clean
// end, inside a run-to-end packet it completes that packet, anywhere else it
// reports truncation. Truncation and a bad tag byte are latched until reset;
// later items still pass their bytes through with the held status.
module pgp_packet_stream_deframer
	import pgpdf_pkg::*;
#(
	parameter int PACKET_COUNT_BITS = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	output logic             item_ready,
	input  wire logic [7:0]  data_byte,
	input  wire logic        end_of_input,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic [5:0]       packet_type,
	output logic [NUM_W-1:0] packet_number,
	output logic [1:0]       byte_role,
	output logic             last_of_packet,
	output logic [1:0]       status
);

	logic  q_full;
	logic  q_push;
	item_t q_item;
	logic  head_valid;
	item_t head_item;
	logic  q_pop;

	// Accept and classify
	pgpdf_front u_front (
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.data_byte    (data_byte),
		.end_of_input (end_of_input),
		.q_full       (q_full),
		.q_push       (q_push),
		.q_item       (q_item)
	);

	// Decouple front and back
	pgpdf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_item  (q_item),
		.full       (q_full),
		.head_valid (head_valid),
		.head_item  (head_item),
		.pop        (q_pop)
	);

	// Parse and present results
	pgpdf_back #(
		.PACKET_COUNT_BITS (PACKET_COUNT_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.head_valid     (head_valid),
		.head_item      (head_item),
		.pop            (q_pop),
		.result_valid   (result_valid),
		.result_ready   (result_ready),
		.out_byte       (out_byte),
		.byte_valid     (byte_valid),
		.packet_type    (packet_type),
		.packet_number  (packet_number),
		.byte_role      (byte_role),
		.last_of_packet (last_of_packet),
		.status         (status)
	);

endmodule

`default_nettype wire

>>> sv/pgpdf_front.sv
// Front end: accepts stream items and classifies each byte ahead of parsing.
`default_nettype none

module pgpdf_front
	import pgpdf_pkg::*;
(
	input  wire logic       item_valid,
	output logic            item_ready,
	input  wire logic [7:0] data_byte,
	input  wire logic       end_of_input,
	input  wire logic       q_full,
	output logic            q_push,
	output item_t           q_item
);

	logic [1:0] old_lt;
	logic [3:0] old_type;

	// Take an item whenever the queue has room
	assign item_ready = !q_full;
	assign q_push     = item_valid && !q_full;

	assign old_lt   = data_byte[1:0];
	assign old_type = data_byte[5:2];

	// Decode the byte as a tag and as a first new-format length byte
	always_comb begin
		q_item           = '0;
		q_item.data      = data_byte;
		q_item.eoi       = end_of_input;
		q_item.tag_ok    = data_byte[7];
		q_item.tag_new   = data_byte[6];
		q_item.tag_type  = data_byte[6] ? data_byte[5:0] : {2'b00, old_type};
		q_item.tag_indet = (old_lt == 2'd3);
		q_item.tag_toend = (old_lt == 2'd3) && ({2'b00, old_type} == TYPE_COMPRESSED);
		case (old_lt)
			2'd0: q_item.tag_len_bytes = 3'd1;
			2'd1: q_item.tag_len_bytes = 3'd2;
			2'd2: q_item.tag_len_bytes = 3'd4;
			default: q_item.tag_len_bytes = 3'd0;
		endcase
		q_item.nl_one  = (data_byte < NL_TWO_BASE);
		q_item.nl_two  = (data_byte >= NL_TWO_BASE) && (data_byte < NL_PART_BASE);
		q_item.nl_five = (data_byte == NL_FIVE);
		q_item.nl_exp  = data_byte[4:0];
	end

endmodule

`default_nettype wire

>>> sv/pgpdf_queue.sv
// Short queue of classified items between front end and parser.
`default_nettype none

module pgpdf_queue
	import pgpdf_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire item_t push_item,
	output logic       full,
	output logic       head_valid,
	output item_t      head_item,
	input  wire logic  pop
);

	item_t              entry_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] count_q;
	logic               do_pop;

	assign full       = (count_q == Q_CNT_W'(Q_DEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	// Store pushed items
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_item;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/pgpdf_back.sv
// Back end: packet framing state machine and result register.
`default_nettype none

module pgpdf_back
	import pgpdf_pkg::*;
#(
	parameter int PACKET_COUNT_BITS = 20
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        head_valid,
	input  wire item_t       head_item,
	output logic             pop,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic [7:0]       out_byte,
	output logic             byte_valid,
	output logic [5:0]       packet_type,
	output logic [NUM_W-1:0] packet_number,
	output logic [1:0]       byte_role,
	output logic             last_of_packet,
	output logic [1:0]       status
);

	phase_t                       phase_q, phase_n;
	len_mode_t                    mode_q, mode_n;
	logic [31:0]                  rem_q, rem_n;
	logic [31:0]                  acc_q, acc_n;
	logic [2:0]                   left_q, left_n;
	logic [5:0]                   type_q, type_n;
	logic [PACKET_COUNT_BITS-1:0] cnt_q, cnt_n;
	status_t                      err_q, err_n;
	logic                         end_pkt;
	logic                         do_fin;
	logic [31:0]                  fin_len;

	role_t                        role_c;
	logic                         last_c;
	status_t                      st_c;

	logic                         fire;
	logic [7:0]                   b;
	logic [31:0]                  nlen2_len;
	logic [31:0]                  lenw_acc;
	logic [2:0]                   lenw_left;
	logic [31:0]                  body_rem;
	logic [31:0]                  och2_len;
	logic [PACKET_COUNT_BITS+NUM_W-1:0] num_ext;

	logic                         valid_q;
	logic [7:0]                   byte_q;
	logic                         bvalid_q;
	logic [5:0]                   ptype_q;
	logic [NUM_W-1:0]             num_q;
	role_t                        role_q;
	logic                         last_q;
	status_t                      st_q;

	// Take the head item when the result register is free or being drained
	assign fire = head_valid && (!valid_q || result_ready);
	assign pop  = fire;
	assign b    = head_item.data;

	// Shared arithmetic of the length and body phases
	assign nlen2_len = acc_q + {24'd0, b} + {24'd0, NL_TWO_BASE};
	assign lenw_acc  = {acc_q[23:0], b};
	assign lenw_left = (left_q != 3'd0) ? left_q - 3'd1 : 3'd0;
	assign body_rem  = (rem_q != 32'd0) ? rem_q - 32'd1 : 32'd0;
	assign och2_len  = acc_q | {24'd0, b};
	assign num_ext   = {{NUM_W{1'b0}}, cnt_q};

	// Next parser state
	always_comb begin
		phase_n = phase_q;
		mode_n  = mode_q;
		rem_n   = rem_q;
		acc_n   = acc_q;
		left_n  = left_q;
		type_n  = type_q;
		cnt_n   = cnt_q;
		err_n   = err_q;
		end_pkt = 1'b0;
		do_fin  = 1'b0;
		fin_len = 32'd0;
		if (err_q != ST_OK) begin
			// hold everything once an error is latched
		end else if (head_item.eoi) begin
			if (phase_q == PH_TAG) begin
				// clean end between packets
			end else if (phase_q == PH_TOEND) begin
				end_pkt = 1'b1;
			end else begin
				err_n = ST_TRUNC;
			end
		end else begin
			case (phase_q)
				PH_NLEN1: begin
					if (head_item.nl_one) begin
						do_fin  = 1'b1;
						fin_len = {24'd0, b};
					end else if (head_item.nl_two) begin
						acc_n   = {19'd0, b[4:0], 8'd0};
						phase_n = PH_NLEN2;
					end else if (head_item.nl_five) begin
						acc_n   = 32'd0;
						left_n  = 3'd4;
						phase_n = PH_LENW;
					end else begin
						rem_n   = 32'd1 << head_item.nl_exp;
						mode_n  = LM_PARTIAL;
						phase_n = PH_BODY;
					end
				end
				PH_NLEN2: begin
					do_fin  = 1'b1;
					fin_len = nlen2_len;
				end
				PH_LENW: begin
					acc_n  = lenw_acc;
					left_n = lenw_left;
					if (lenw_left == 3'd0) begin
						do_fin  = 1'b1;
						fin_len = lenw_acc;
					end
				end
				PH_BODY: begin
					rem_n = body_rem;
					if (body_rem == 32'd0) begin
						if (mode_q == LM_PARTIAL) begin
							phase_n = PH_NLEN1;
						end else if (mode_q == LM_OCHUNK) begin
							phase_n = PH_OCH1;
						end else begin
							end_pkt = 1'b1;
						end
					end
				end
				PH_OCH1: begin
					acc_n   = {16'd0, b, 8'd0};
					phase_n = PH_OCH2;
				end
				PH_OCH2: begin
					acc_n = och2_len;
					if (och2_len == 32'd0) begin
						end_pkt = 1'b1;
					end else begin
						rem_n   = och2_len;
						phase_n = PH_BODY;
					end
				end
				PH_TOEND: begin
					// body runs until end of input
				end
				default: begin
					if (!head_item.tag_ok) begin
						err_n   = ST_BADTAG;
						phase_n = PH_TAG;
					end else begin
						mode_n = LM_DEFINITE;
						acc_n  = 32'd0;
						rem_n  = 32'd0;
						type_n = head_item.tag_type;
						if (head_item.tag_new) begin
							phase_n = PH_NLEN1;
						end else if (head_item.tag_indet) begin
							if (head_item.tag_toend) begin
								mode_n  = LM_TOEND;
								phase_n = PH_TOEND;
							end else begin
								mode_n  = LM_OCHUNK;
								phase_n = PH_OCH1;
							end
						end else begin
							left_n  = head_item.tag_len_bytes;
							phase_n = PH_LENW;
						end
					end
				end
			endcase
		end
		// a known definite length starts the body or ends an empty packet
		if (do_fin) begin
			mode_n = LM_DEFINITE;
			rem_n  = fin_len;
			if (fin_len == 32'd0) begin
				end_pkt = 1'b1;
			end else begin
				phase_n = PH_BODY;
			end
		end
		if (end_pkt) begin
			cnt_n   = cnt_q + {{(PACKET_COUNT_BITS-1){1'b0}}, 1'b1};
			phase_n = PH_TAG;
			mode_n  = LM_DEFINITE;
			rem_n   = 32'd0;
			acc_n   = 32'd0;
			left_n  = 3'd0;
		end
	end

	// Role, last flag and status of the current item
	always_comb begin
		role_c = ROLE_TAG;
		last_c = 1'b0;
		st_c   = ST_OK;
		if (err_q != ST_OK) begin
			st_c = err_q;
		end else if (head_item.eoi) begin
			if (phase_q == PH_TAG) begin
				st_c = ST_END;
			end else if (phase_q == PH_TOEND) begin
				st_c   = ST_END;
				last_c = 1'b1;
			end else begin
				st_c   = ST_TRUNC;
				last_c = 1'b1;
			end
		end else begin
			last_c = end_pkt;
			case (phase_q)
				PH_NLEN1, PH_NLEN2, PH_LENW: begin
					role_c = (mode_q == LM_PARTIAL) ? ROLE_CHUNK : ROLE_LEN;
				end
				PH_BODY, PH_TOEND: begin
					role_c = ROLE_BODY;
				end
				PH_OCH1, PH_OCH2: begin
					role_c = ROLE_CHUNK;
				end
				default: begin
					role_c = ROLE_TAG;
					if (!head_item.tag_ok) begin
						st_c = ST_BADTAG;
					end
				end
			endcase
		end
	end

	// Update parser state on each transfer out of the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TAG;
			mode_q  <= LM_DEFINITE;
			rem_q   <= '0;
			acc_q   <= '0;
			left_q  <= '0;
			type_q  <= '0;
			cnt_q   <= '0;
			err_q   <= ST_OK;
		end else if (fire) begin
			phase_q <= phase_n;
			mode_q  <= mode_n;
			rem_q   <= rem_n;
			acc_q   <= acc_n;
			left_q  <= left_n;
			type_q  <= type_n;
			cnt_q   <= cnt_n;
			err_q   <= err_n;
		end
	end

	// Result valid: set on load, drop on transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (fire) begin
			valid_q <= 1'b1;
		end else if (result_ready) begin
			valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			byte_q   <= head_item.eoi ? 8'd0 : b;
			bvalid_q <= !head_item.eoi;
			ptype_q  <= type_n;
			num_q    <= num_ext[NUM_W-1:0];
			role_q   <= role_c;
			last_q   <= last_c;
			st_q     <= st_c;
		end
	end

	assign result_valid   = valid_q;
	assign out_byte       = byte_q;
	assign byte_valid     = bvalid_q;
	assign packet_type    = ptype_q;
	assign packet_number  = num_q;
	assign byte_role      = role_q;
	assign last_of_packet = last_q;
	assign status         = st_q;

`ifndef SYNTHESIS
	a_err_held: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q != ST_OK) |=> (err_q == $past(err_q)))
		else $error("latched error changed");

	a_partial_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(mode_q == LM_PARTIAL) |-> (phase_q == PH_NLEN1 || phase_q == PH_NLEN2 ||
			phase_q == PH_LENW || phase_q == PH_BODY))
		else $error("partial chunk mode outside length or body phase");

	a_status_role: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && st_q != ST_OK) |-> (role_q == ROLE_TAG))
		else $error("nonzero status with a non-tag role");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && end_pkt) |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("packet counter did not advance on packet end");
`endif

endmodule

`default_nettype wire

>>> test/tb_top.sv
// Testbench for the packet stream deframer: packet streams in, tagged bytes checked.
`default_nettype none

module tb_top;
	import pgpdf_pkg::*;

	localparam int ITEMS_WANTED = 1950;
	localparam int HOLD_CYCLES  = 400;
	localparam int STALL_LIMIT  = 5000;
	localparam int DRAIN_CYCLES = 10;
	localparam int PRINT_LIMIT  = 40;

	// One stream byte or end mark
	typedef struct packed {
		logic [7:0] b;
		logic       eoi;
	} stream_item_t;

	// One tagged byte as the block should report it
	typedef struct packed {
		logic [7:0]       data;
		logic             valid;
		logic [5:0]       ptype;
		logic [NUM_W-1:0] pnum;
		role_t            role;
		logic             last;
		status_t          st;
	} framed_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             item_valid = 1'b0;
	logic             item_ready;
	logic [7:0]       data_byte = 8'd0;
	logic             end_of_input = 1'b0;
	logic             result_valid;
	logic             result_ready = 1'b0;
	logic [7:0]       out_byte;
	logic             byte_valid;
	logic [5:0]       packet_type;
	logic [NUM_W-1:0] packet_number;
	logic [1:0]       byte_role;
	logic             last_of_packet;
	logic [1:0]       status;

	stream_item_t stream_items[$];
	framed_t      expected_tags[$];
	int           total_items = 0;
	int           items_taken = 0;
	int           hold_at = 0;
	int           hold_left = 0;
	bit           hold_done = 1'b0;
	int           idle_cycles = 0;
	int           mismatches = 0;

	// Framing state of the predictor
	phase_t           fr_phase = PH_TAG;
	len_mode_t        fr_mode = LM_DEFINITE;
	logic [31:0]      fr_remain = '0;
	logic [31:0]      fr_acc = '0;
	logic [2:0]       fr_lenleft = '0;
	logic [5:0]       fr_type = '0;
	logic [NUM_W-1:0] pkt_count = '0;
	status_t          held_err = ST_OK;

	pgp_packet_stream_deframer #(
		.PACKET_COUNT_BITS(NUM_W)
	) u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.item_valid    (item_valid),
		.item_ready    (item_ready),
		.data_byte     (data_byte),
		.end_of_input  (end_of_input),
		.result_valid  (result_valid),
		.result_ready  (result_ready),
		.out_byte      (out_byte),
		.byte_valid    (byte_valid),
		.packet_type   (packet_type),
		.packet_number (packet_number),
		.byte_role     (byte_role),
		.last_of_packet(last_of_packet),
		.status        (status)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Close the current packet and wait for a tag
	function automatic void close_packet();
		pkt_count  = pkt_count + 1'b1;
		fr_phase   = PH_TAG;
		fr_mode    = LM_DEFINITE;
		fr_remain  = '0;
		fr_acc     = '0;
		fr_lenleft = '0;
	endfunction

	// Load a definite length; a zero length closes the packet at once
	function automatic logic take_length(input logic [31:0] len);
		fr_mode   = LM_DEFINITE;
		fr_remain = len;
		if (len == 0) begin
			close_packet();
			return 1'b1;
		end
		fr_phase = PH_BODY;
		return 1'b0;
	endfunction

	// Tag one stream item and advance the framing state
	function automatic framed_t frame_item(input logic [7:0] b, input logic eoi);
		framed_t r;
		role_t   len_role;
		r.data   = eoi ? 8'd0 : b;
		r.valid  = !eoi;
		r.pnum   = pkt_count;
		r.role   = ROLE_TAG;
		r.last   = 1'b0;
		r.st     = ST_OK;
		len_role = (fr_mode == LM_PARTIAL) ? ROLE_CHUNK : ROLE_LEN;
		if (held_err != ST_OK) begin
			r.st = held_err;
		end else if (eoi) begin
			if (fr_phase == PH_TAG) begin
				r.st = ST_END;
			end else if (fr_phase == PH_TOEND) begin
				r.st   = ST_END;
				r.last = 1'b1;
				close_packet();
			end else begin
				r.st     = ST_TRUNC;
				r.last   = 1'b1;
				held_err = ST_TRUNC;
			end
		end else begin
			case (fr_phase)
				PH_NLEN1: begin
					r.role = len_role;
					if (b < NL_TWO_BASE) begin
						r.last = take_length({24'd0, b});
					end else if (b < NL_PART_BASE) begin
						fr_acc   = {16'd0, b - NL_TWO_BASE, 8'd0};
						fr_phase = PH_NLEN2;
					end else if (b == NL_FIVE) begin
						fr_acc     = '0;
						fr_lenleft = 3'd4;
						fr_phase   = PH_LENW;
					end else begin
						fr_remain = 32'd1 << b[4:0];
						fr_mode   = LM_PARTIAL;
						fr_phase  = PH_BODY;
					end
				end
				PH_NLEN2: begin
					r.role = len_role;
					r.last = take_length(fr_acc + {24'd0, b} + {24'd0, NL_TWO_BASE});
				end
				PH_LENW: begin
					r.role = len_role;
					fr_acc = {fr_acc[23:0], b};
					if (fr_lenleft != 0)
						fr_lenleft = fr_lenleft - 1'b1;
					if (fr_lenleft == 0)
						r.last = take_length(fr_acc);
				end
				PH_BODY: begin
					r.role = ROLE_BODY;
					if (fr_remain != 0)
						fr_remain = fr_remain - 1'b1;
					if (fr_remain == 0) begin
						if (fr_mode == LM_PARTIAL) begin
							fr_phase = PH_NLEN1;
						end else if (fr_mode == LM_OCHUNK) begin
							fr_phase = PH_OCH1;
						end else begin
							r.last = 1'b1;
							close_packet();
						end
					end
				end
				PH_OCH1: begin
					r.role   = ROLE_CHUNK;
					fr_acc   = {16'd0, b, 8'd0};
					fr_phase = PH_OCH2;
				end
				PH_OCH2: begin
					r.role = ROLE_CHUNK;
					fr_acc = fr_acc | {24'd0, b};
					if (fr_acc == 0) begin
						r.last = 1'b1;
						close_packet();
					end else begin
						fr_remain = fr_acc;
						fr_phase  = PH_BODY;
					end
				end
				PH_TOEND: begin
					r.role = ROLE_BODY;
				end
				default: begin
					// Expect a tag byte; bit 7 clear is a bad tag
					r.role = ROLE_TAG;
					if (!b[7]) begin
						r.st     = ST_BADTAG;
						held_err = ST_BADTAG;
						fr_phase = PH_TAG;
					end else begin
						fr_mode   = LM_DEFINITE;
						fr_acc    = '0;
						fr_remain = '0;
						if (b[6]) begin
							fr_type  = b[5:0];
							fr_phase = PH_NLEN1;
						end else begin
							fr_type = {2'b00, b[5:2]};
							if (b[1:0] == 2'd3) begin
								if (fr_type == TYPE_COMPRESSED) begin
									fr_mode  = LM_TOEND;
									fr_phase = PH_TOEND;
								end else begin
									fr_mode  = LM_OCHUNK;
									fr_phase = PH_OCH1;
								end
							end else begin
								fr_lenleft = (b[1:0] == 2'd0) ? 3'd1 :
									(b[1:0] == 2'd1) ? 3'd2 : 3'd4;
								fr_phase = PH_LENW;
							end
						end
					end
				end
			endcase
		end
		r.ptype = fr_type;
		return r;
	endfunction

	// Stimulus builders
	task automatic put_byte(input logic [7:0] b);
		stream_items.push_back('{b, 1'b0});
	endtask

	task automatic put_end();
		stream_items.push_back('{8'($urandom), 1'b1});
	endtask

	task automatic put_body(input int n);
		repeat (n) put_byte(8'($urandom));
	endtask

	// Write n big-endian over nbytes bytes
	task automatic put_be(input logic [31:0] n, input int nbytes);
		for (int i = nbytes - 1; i >= 0; i--)
			put_byte(8'(n >> (8 * i)));
	endtask

	// Mostly short lengths, sometimes up to the one-byte top, rarely two-byte sizes
	function automatic int rand_len();
		int r;
		r = $urandom_range(99);
		if (r < 93)
			return $urandom_range(0, 12);
		if (r < 97)
			return $urandom_range(13, 191);
		return $urandom_range(192, 260);
	endfunction

	// New-format definite length in one, two or five bytes
	task automatic put_new_len(input int n);
		int m;
		if ($urandom_range(3) == 0) begin
			put_byte(NL_FIVE);
			put_be(n, 4);
		end else if (n < 192) begin
			put_byte(8'(n));
		end else begin
			m = n - 192;
			put_byte(NL_TWO_BASE + 8'(m / 256));
			put_byte(8'(m % 256));
		end
	endtask

	task automatic put_random_packet();
		int         pick;
		int         n;
		int         lt;
		logic [3:0] typ;
		pick = $urandom_range(99);
		if (pick < 5) begin
			put_end();
		end else if (pick < 50) begin
			// new format, sometimes with partial chunks before the final length
			put_byte({2'b11, 6'($urandom)});
			if ($urandom_range(99) < 20) begin
				repeat ($urandom_range(1, 3)) begin
					n = ($urandom_range(99) < 90) ? $urandom_range(0, 4) : $urandom_range(5, 6);
					put_byte(NL_PART_BASE + 8'(n));
					put_body(1 << n);
				end
			end
			n = rand_len();
			put_new_len(n);
			put_body(n);
		end else begin
			// old format
			typ = 4'($urandom);
			lt  = $urandom_range(3);
			if (lt == 3 && $urandom_range(2) == 0)
				typ = TYPE_COMPRESSED[3:0];
			put_byte({2'b10, typ, 2'(lt)});
			case (lt)
				0: begin
					n = ($urandom_range(99) < 97) ? $urandom_range(0, 12) : 255;
					put_byte(8'(n));
					put_body(n);
				end
				1: begin
					n = rand_len();
					put_be(n, 2);
					put_body(n);
				end
				2: begin
					n = rand_len();
					put_be(n, 4);
					put_body(n);
				end
				default: begin
					if ({2'b00, typ} == TYPE_COMPRESSED) begin
						put_body($urandom_range(0, 12));
						put_end();
					end else begin
						repeat ($urandom_range(0, 3)) begin
							n = $urandom_range(1, 12);
							put_be(n, 2);
							put_body(n);
						end
						put_be(0, 2);
					end
				end
			endcase
		end
	endtask

	function automatic int sender_idle_pct();
		if (items_taken < total_items / 3)
			return 28;
		if (items_taken < 2 * total_items / 3)
			return 73;
		return 0;
	endfunction

	function automatic int receiver_idle_pct();
		if (items_taken < total_items / 3)
			return 73;
		if (items_taken < 2 * total_items / 3)
			return 28;
		return 0;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH: %s", msg);
		mismatches++;
	endtask

	task automatic compare_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got 0x%0h expected 0x%0h", name, got, want));
	endtask

	// Drive stream items; predict each transfer as it is accepted
	always @(posedge clk) begin
		stream_item_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				expected_tags.push_back(frame_item(data_byte, end_of_input));
				items_taken <= items_taken + 1;
			end
			if (!item_valid || item_ready) begin
				if (stream_items.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
					nxt = stream_items.pop_front();
					item_valid   <= 1'b1;
					data_byte    <= nxt.b;
					end_of_input <= nxt.eoi;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// Check each result transfer; stall the result side, once for a long stretch
	always @(posedge clk) begin
		framed_t want;
		if (!arst_n) begin
			result_ready <= 1'b0;
		end else begin
			if (result_valid && result_ready) begin
				if (expected_tags.size() == 0) begin
					report_mismatch($sformatf("result 0x%0h with nothing expected", out_byte));
				end else begin
					want = expected_tags.pop_front();
					compare_field("out_byte", 32'(out_byte), 32'(want.data));
					compare_field("byte_valid", 32'(byte_valid), 32'(want.valid));
					compare_field("packet_type", 32'(packet_type), 32'(want.ptype));
					compare_field("packet_number", 32'(packet_number), 32'(want.pnum));
					compare_field("byte_role", 32'(byte_role), 32'(want.role));
					compare_field("last_of_packet", 32'(last_of_packet), 32'(want.last));
					compare_field("status", 32'(status), 32'(want.st));
				end
			end
			if (hold_left != 0) begin
				hold_left    <= hold_left - 1;
				result_ready <= 1'b0;
			end else if (!hold_done && items_taken >= hold_at) begin
				hold_left    <= HOLD_CYCLES;
				hold_done    <= 1'b1;
				result_ready <= 1'b0;
			end else begin
				result_ready <= ($urandom_range(99) >= receiver_idle_pct());
			end
		end
	end

	// End the run when no transfer happens for too long
	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// new format, type 63, zero length closes on the length byte
		put_byte(8'hFF);
		put_byte(8'h00);
		// new format, type 0, one body byte
		put_byte(8'hC0);
		put_byte(8'h01);
		put_body(1);
		// new format, five-byte zero length
		put_byte(8'hC5);
		put_byte(NL_FIVE);
		put_be(0, 4);
		// partial chunk of one byte, then a zero final length
		put_byte(8'hC2);
		put_byte(NL_PART_BASE);
		put_body(1);
		put_byte(8'h00);
		// old format, type 15, one-byte zero length
		put_byte(8'hBC);
		put_byte(8'h00);
		// old format indeterminate: one chunk of one byte, then the zero chunk
		put_byte(8'h83);
		put_be(1, 2);
		put_body(1);
		put_be(0, 2);
		// compressed packet running to end of input
		put_byte(8'hA3);
		put_body(1);
		put_end();
		// clean end between packets
		put_end();

		while (stream_items.size() < ITEMS_WANTED)
			put_random_packet();

		// finish with one latched error and items after it
		case ($urandom_range(2))
			0: put_byte(8'($urandom_range(0, 127)));
			1: begin
				put_byte({2'b11, 6'($urandom)});
				put_byte(8'hFE);
				put_body($urandom_range(0, 5));
				put_end();
			end
			default: begin
				put_byte({2'b11, 6'($urandom)});
				put_byte(NL_FIVE);
				put_be(32'hFFFF_FFFF, 4);
				put_body($urandom_range(0, 5));
				put_end();
			end
		endcase
		repeat (12) begin
			if ($urandom_range(3) == 0)
				put_end();
			else
				put_byte(8'($urandom));
		end

		total_items = stream_items.size();
		hold_at     = 5 * total_items / 6;

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (items_taken != total_items) @(posedge clk);
		while (expected_tags.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		if (mismatches == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

`default_nettype wire
